FILE: hw/rtl/efsw_pkg.sv
// Shared types, constants and the sequencer program of the e-paper frame stream writer.
`timescale 1ns / 1ps

package efsw_pkg;

  // Field and register widths
  localparam int BYTE_W    = 8;
  localparam int COLS_W    = 5;
  localparam int ROWS_W    = 9;
  localparam int XEND_W    = 11;
  localparam int YEND_W    = 10;
  localparam int LINE_W    = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;

  // Row buffer sizing and burst limits
  localparam int DEF_MAX_ROW_BYTES = 32;
  localparam int BURST_ROW_CAP     = 25;
  localparam int RESULT_CAP        = 64;
  localparam int CNT_W             = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_RES_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X_END  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Y_END  = 3'd4;

  // Panel command bytes
  localparam logic [7:0] CMD_WRITE_RAM   = 8'h24;
  localparam logic [7:0] CMD_X_WINDOW    = 8'h44;
  localparam logic [7:0] CMD_Y_WINDOW    = 8'h45;
  localparam logic [7:0] CMD_X_CURSOR    = 8'h4E;
  localparam logic [7:0] CMD_Y_CURSOR    = 8'h4F;
  localparam logic [7:0] CMD_UPDATE_CTRL = 8'h22;
  localparam logic [7:0] UPDATE_SEQ      = 8'hC4;
  localparam logic [7:0] CMD_ACTIVATE    = 8'h20;
  localparam logic [7:0] CMD_TERMINATE   = 8'hFF;
  localparam logic [7:0] BYTE_ZERO       = 8'h00;

  // Address width of a memory of the given depth, at least one bit
  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Double each pixel bit of a nibble into a byte
  function automatic logic [7:0] double_nibble(input logic [3:0] nib);
    return {nib[3], nib[3], nib[2], nib[2], nib[1], nib[1], nib[0], nib[0]};
  endfunction

  // Byte source select of a control word
  typedef enum logic [3:0] {
    SRC_CONST  = 4'd0,
    SRC_WX     = 4'd1,
    SRC_YLO    = 4'd2,
    SRC_YHI    = 4'd3,
    SRC_LLO    = 4'd4,
    SRC_LHI    = 4'd5,
    SRC_PIX    = 4'd6,
    SRC_PIX_HI = 4'd7,
    SRC_PIX_LO = 4'd8,
    SRC_RAM_HI = 4'd9,
    SRC_RAM_LO = 4'd10
  } src_t;

  // Jump condition of a control word
  typedef enum logic [3:0] {
    C_NEVER    = 4'd0,
    C_ALWAYS   = 4'd1,
    C_NO_FRAME = 4'd2,
    C_NO_ROW   = 4'd3,
    C_HALF     = 4'd4,
    C_FULL     = 4'd5,
    C_NO_REND  = 4'd6,
    C_MORE     = 4'd7,
    C_NO_FEND  = 4'd8
  } cond_t;

  localparam int PC_W = 6;

  // One control word of the program
  typedef struct packed {
    logic            emit;
    logic            is_data;
    src_t            src;
    logic [7:0]      konst;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            line_odd;
    logic            rd_inc;
  } ucode_t;

  // Status the sequencer branches on
  typedef struct packed {
    logic fs;
    logic rs;
    logic half;
    logic row_end;
    logic frame_end;
    logic more;
  } seq_stat_t;

  // Program entry points
  localparam logic [PC_W-1:0] ST_FRAME       = 6'd0;
  localparam logic [PC_W-1:0] ST_ROW         = 6'd9;
  localparam logic [PC_W-1:0] ST_PIX         = 6'd16;
  localparam logic [PC_W-1:0] ST_PIX_HALF    = 6'd18;
  localparam logic [PC_W-1:0] ST_ROW_END     = 6'd20;
  localparam logic [PC_W-1:0] ST_REPLAY      = 6'd21;
  localparam logic [PC_W-1:0] ST_REPLAY_DATA = 6'd28;
  localparam logic [PC_W-1:0] ST_FRAME_END   = 6'd30;
  localparam logic [PC_W-1:0] ST_DONE        = 6'd35;

  // Build a control word
  function automatic ucode_t uw(input logic emit, input logic is_data, input src_t src,
                                input logic [7:0] konst, input cond_t cond,
                                input logic [PC_W-1:0] target, input logic line_odd,
                                input logic rd_inc);
    ucode_t w;
    w.emit     = emit;
    w.is_data  = is_data;
    w.src      = src;
    w.konst    = konst;
    w.cond     = cond;
    w.target   = target;
    w.line_odd = line_odd;
    w.rd_inc   = rd_inc;
    return w;
  endfunction

  function automatic ucode_t cmd(input logic [7:0] k);
    return uw(1'b1, 1'b0, SRC_CONST, k, C_NEVER, ST_FRAME, 1'b0, 1'b0);
  endfunction

  function automatic ucode_t dat(input src_t s, input logic [7:0] k);
    return uw(1'b1, 1'b1, s, k, C_NEVER, ST_FRAME, 1'b0, 1'b0);
  endfunction

  function automatic ucode_t br(input cond_t c, input logic [PC_W-1:0] t);
    return uw(1'b0, 1'b0, SRC_CONST, BYTE_ZERO, c, t, 1'b0, 1'b0);
  endfunction

  // Program ROM: one control word per step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = br(C_NEVER, ST_DONE);
    case (pc)
      // Frame start: RAM window
      6'd0:  w = br(C_NO_FRAME, ST_ROW);
      6'd1:  w = cmd(CMD_X_WINDOW);
      6'd2:  w = dat(SRC_CONST, BYTE_ZERO);
      6'd3:  w = dat(SRC_WX, BYTE_ZERO);
      6'd4:  w = cmd(CMD_Y_WINDOW);
      6'd5:  w = dat(SRC_CONST, BYTE_ZERO);
      6'd6:  w = dat(SRC_CONST, BYTE_ZERO);
      6'd7:  w = dat(SRC_YLO, BYTE_ZERO);
      6'd8:  w = dat(SRC_YHI, BYTE_ZERO);
      // Row start: cursor and write command
      6'd9:  w = br(C_NO_ROW, ST_PIX);
      6'd10: w = cmd(CMD_X_CURSOR);
      6'd11: w = dat(SRC_CONST, BYTE_ZERO);
      6'd12: w = cmd(CMD_Y_CURSOR);
      6'd13: w = dat(SRC_LLO, BYTE_ZERO);
      6'd14: w = dat(SRC_LHI, BYTE_ZERO);
      6'd15: w = cmd(CMD_WRITE_RAM);
      // Pixel data
      6'd16: w = br(C_HALF, ST_PIX_HALF);
      6'd17: w = uw(1'b1, 1'b1, SRC_PIX, BYTE_ZERO, C_ALWAYS, ST_ROW_END, 1'b0, 1'b0);
      6'd18: w = dat(SRC_PIX_HI, BYTE_ZERO);
      6'd19: w = dat(SRC_PIX_LO, BYTE_ZERO);
      // Row end: replay on the odd line in half mode
      6'd20: w = br(C_NO_REND, ST_DONE);
      6'd21: w = uw(1'b0, 1'b0, SRC_CONST, BYTE_ZERO, C_FULL, ST_FRAME_END, 1'b1, 1'b0);
      6'd22: w = cmd(CMD_X_CURSOR);
      6'd23: w = dat(SRC_CONST, BYTE_ZERO);
      6'd24: w = cmd(CMD_Y_CURSOR);
      6'd25: w = dat(SRC_LLO, BYTE_ZERO);
      6'd26: w = dat(SRC_LHI, BYTE_ZERO);
      6'd27: w = cmd(CMD_WRITE_RAM);
      6'd28: w = dat(SRC_RAM_HI, BYTE_ZERO);
      6'd29: w = uw(1'b1, 1'b1, SRC_RAM_LO, BYTE_ZERO, C_MORE, ST_REPLAY_DATA, 1'b0, 1'b1);
      // Frame end: display update
      6'd30: w = br(C_NO_FEND, ST_DONE);
      6'd31: w = cmd(CMD_UPDATE_CTRL);
      6'd32: w = dat(SRC_CONST, UPDATE_SEQ);
      6'd33: w = cmd(CMD_ACTIVATE);
      6'd34: w = cmd(CMD_TERMINATE);
      default: w = br(C_NEVER, ST_DONE);
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/efsw_if.sv
// Valid/ready stream interfaces for pixel bytes in and SPI bytes out.
`timescale 1ns / 1ps

interface efsw_in_if import efsw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface efsw_out_if import efsw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              is_data;
  logic              last_of_run;

  modport source (output valid, output out_byte, output is_data, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input is_data, input last_of_run,
                  output ready);
endinterface

FILE: hw/rtl/epaper_frame_stream_writer_core.sv
// Top level: configuration, frame/row state, byte datapath and output staging.
`timescale 1ns / 1ps

// Takes a 1-bit-per-pixel image one byte per beat in row-major order and emits the
// panel's SPI byte stream, each byte tagged data or command, with last_of_run on the
// final byte caused by an input beat. The first beat of a frame sends the RAM window
// (0x44, 0x45), each row opens with cursor commands 0x4E/0x4F and 0x24, half mode
// doubles every pixel and replays the buffered row on the odd line, and the last row
// closes with 0x22, 0xC4, 0x20, 0xFF. At most 64 bytes come out per input beat.
// One input beat is handled at a time by a microcoded sequencer that issues one output
// byte per cycle while the receiver takes bytes, and also passes four to six branch steps
// per item that emit nothing. A receiver stall holds the sequencer. When it is done, the
// last byte is handed to the output register before the next beat is taken. The row
// buffer is one RAM with MAX_ROW_BYTES entries; it needs no clearing after reset.
// Write configuration only while the block is idle.

module epaper_frame_stream_writer_core import efsw_pkg::*; #(
  parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  efsw_in_if.sink              pix_in,
  efsw_out_if.source           res_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW       = addr_w(MAX_ROW_BYTES);
  localparam int CAP_COLS = (BURST_ROW_CAP < MAX_ROW_BYTES) ? BURST_ROW_CAP : MAX_ROW_BYTES;

  // Configuration registers
  logic              half_res_mode;
  logic [COLS_W-1:0] row_bytes;
  logic [ROWS_W-1:0] row_count;
  logic [XEND_W-1:0] window_x_end;
  logic [YEND_W-1:0] window_y_end;

  // Frame position
  logic              frame_open;
  logic [COLS_W-1:0] column_index;
  logic [ROWS_W-1:0] row_index;

  // Per-item decisions and operands
  logic              fs;
  logic              rs;
  logic              row_end;
  logic              frame_end;
  logic [BYTE_W-1:0] pix;
  logic [LINE_W-1:0] line;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     rd_addr_next;
  logic [CNT_W-1:0]  cnt;

  // Pending byte and output register
  logic              p_valid;
  logic [BYTE_W-1:0] p_byte;
  logic              p_data;
  logic              o_valid;
  logic [BYTE_W-1:0] o_byte;
  logic              o_data;
  logic              o_last;

  // Combinational helpers
  logic              accept;
  logic [COLS_W-1:0] eff_cols;
  logic [ROWS_W-1:0] eff_rows;
  logic [COLS_W-1:0] ci;
  logic [ROWS_W-1:0] ri;
  logic              ci_end;
  logic              ri_end;
  logic [BYTE_W-1:0] ram_q;
  logic [BYTE_W-1:0] byte_sel;
  logic              o_free;
  logic              full;
  logic              push_ok;
  logic              advance;
  logic              fire;
  logic              idle;
  ucode_t            uc;
  seq_stat_t         stat;

  // Effective row length and row count
  always_comb begin
    eff_cols = (row_bytes == '0) ? COLS_W'(1) : row_bytes;
    if (eff_cols > COLS_W'(CAP_COLS)) begin
      eff_cols = COLS_W'(CAP_COLS);
    end
    eff_rows = (row_count == '0) ? ROWS_W'(1) : row_count;
  end

  // Position seen by the incoming beat: a closed frame restarts at the origin
  assign ci     = frame_open ? column_index : '0;
  assign ri     = frame_open ? row_index : '0;
  assign ci_end = ({1'b0, ci} + 1'b1) >= {1'b0, eff_cols};
  assign ri_end = ({1'b0, ri} + 1'b1) >= {1'b0, eff_rows};

  assign accept       = pix_in.valid && pix_in.ready;
  assign pix_in.ready = idle && !p_valid;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      half_res_mode <= 1'b1;
      row_bytes     <= COLS_W'(13);
      row_count     <= ROWS_W'(100);
      window_x_end  <= XEND_W'(199);
      window_y_end  <= YEND_W'(199);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_RES_MODE: half_res_mode <= cfg_data[0];
        REG_ROW_BYTES:     row_bytes     <= cfg_data[COLS_W-1:0];
        REG_ROW_COUNT:     row_count     <= cfg_data[ROWS_W-1:0];
        REG_WINDOW_X_END:  window_x_end  <= cfg_data[XEND_W-1:0];
        REG_WINDOW_Y_END:  window_y_end  <= cfg_data[YEND_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the frame position once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open   <= 1'b0;
      column_index <= '0;
      row_index    <= '0;
    end else if (accept) begin
      if (ci_end) begin
        column_index <= '0;
        if (ri_end) begin
          row_index  <= '0;
          frame_open <= 1'b0;
        end else begin
          row_index  <= ri + 1'b1;
          frame_open <= 1'b1;
        end
      end else begin
        column_index <= ci + 1'b1;
        row_index    <= ri;
        frame_open   <= 1'b1;
      end
    end
  end

  // Latch the decisions of the item
  always_ff @(posedge clk) begin
    if (rst) begin
      fs        <= 1'b0;
      rs        <= 1'b0;
      row_end   <= 1'b0;
      frame_end <= 1'b0;
    end else if (accept) begin
      fs        <= !frame_open;
      rs        <= (ci == '0);
      row_end   <= ci_end;
      frame_end <= ci_end && ri_end;
    end
  end

  // Pixel, cursor line and replay address
  always_comb begin
    rd_addr_next = rd_addr;
    if (advance && uc.line_odd) begin
      rd_addr_next = '0;
    end else if (advance && uc.rd_inc) begin
      rd_addr_next = rd_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix  <= pix_in.pixel_byte;
      line <= half_res_mode ? {ri, 1'b0} : {1'b0, ri};
    end else if (advance && uc.line_odd) begin
      line[0] <= 1'b1;
    end
    rd_addr <= rd_addr_next;
  end

  // Row buffer: store every beat at its column, read ahead for the replay
  efsw_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_ROW_BYTES)
  ) u_row_store (
    .clk   (clk),
    .we    (accept),
    .waddr (ci[AW-1:0]),
    .wdata (pix_in.pixel_byte),
    .raddr (rd_addr_next),
    .rdata (ram_q)
  );

  // Sequencer status
  always_comb begin
    stat.fs        = fs;
    stat.rs        = rs;
    stat.half      = half_res_mode;
    stat.row_end   = row_end;
    stat.frame_end = frame_end;
    stat.more      = ({1'b0, rd_addr} + 1'b1) < (COLS_W + 1)'(eff_cols);
  end

  efsw_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .advance (advance),
    .stat    (stat),
    .uc      (uc),
    .idle    (idle)
  );

  // Select the byte of the current step
  always_comb begin
    unique case (uc.src)
      SRC_CONST:  byte_sel = uc.konst;
      SRC_WX:     byte_sel = window_x_end[XEND_W-1:3];
      SRC_YLO:    byte_sel = window_y_end[7:0];
      SRC_YHI:    byte_sel = {6'b0, window_y_end[YEND_W-1:8]};
      SRC_LLO:    byte_sel = line[7:0];
      SRC_LHI:    byte_sel = {6'b0, line[LINE_W-1:8]};
      SRC_PIX:    byte_sel = pix;
      SRC_PIX_HI: byte_sel = double_nibble(pix[7:4]);
      SRC_PIX_LO: byte_sel = double_nibble(pix[3:0]);
      SRC_RAM_HI: byte_sel = double_nibble(ram_q[7:4]);
      SRC_RAM_LO: byte_sel = double_nibble(ram_q[3:0]);
      default:    byte_sel = uc.konst;
    endcase
  end

  // Step control: drop bytes past the burst limit, stall when staging is full
  assign o_free  = !o_valid || res_out.ready;
  assign full    = (cnt == CNT_W'(RESULT_CAP));
  assign push_ok = !p_valid || o_free;
  assign advance = !idle && (!uc.emit || full || push_ok);
  assign fire    = !idle && uc.emit && !full && push_ok;

  // Count bytes of the item
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= '0;
    end else if (fire) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Hold the newest byte back until the next one shows whether it was the last
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (fire) begin
        p_valid <= 1'b1;
      end else if (idle && p_valid && o_free) begin
        p_valid <= 1'b0;
      end
      if ((fire && p_valid) || (idle && p_valid && o_free)) begin
        o_valid <= 1'b1;
      end else if (res_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      p_byte <= byte_sel;
      p_data <= uc.is_data;
    end
    if (fire && p_valid) begin
      o_byte <= p_byte;
      o_data <= p_data;
      o_last <= 1'b0;
    end else if (idle && p_valid && o_free) begin
      o_byte <= p_byte;
      o_data <= p_data;
      o_last <= 1'b1;
    end
  end

  assign res_out.valid       = o_valid;
  assign res_out.out_byte    = o_byte;
  assign res_out.is_data     = o_data;
  assign res_out.last_of_run = o_last;

endmodule

FILE: hw/rtl/efsw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module efsw_ram import efsw_pkg::*; #(
  parameter int WIDTH = BYTE_W,
  parameter int DEPTH = DEF_MAX_ROW_BYTES
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [addr_w(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]          wdata,
  input  logic [addr_w(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/efsw_seq.sv
// Microcode sequencer: step counter, program ROM and conditional jumps.
`timescale 1ns / 1ps

module efsw_seq import efsw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      advance,
  input  seq_stat_t stat,
  output ucode_t    uc,
  output logic      idle
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  assign uc   = ucode_rom(pc);
  assign idle = (pc == ST_DONE);

  // Evaluate the jump condition of the current step
  always_comb begin
    unique case (uc.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_FRAME: take = !stat.fs;
      C_NO_ROW:   take = !stat.rs;
      C_HALF:     take = stat.half;
      C_FULL:     take = !stat.half;
      C_NO_REND:  take = !stat.row_end;
      C_MORE:     take = stat.more;
      C_NO_FEND:  take = !stat.frame_end;
      default:    take = 1'b0;
    endcase
  end

  // Hold at the done step until a beat arrives, else step or jump
  always_comb begin
    pc_next = pc;
    if (idle) begin
      if (start) begin
        pc_next = ST_FRAME;
      end
    end else if (advance) begin
      pc_next = take ? uc.target : pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_DONE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
